// ----- rtl/ptm_pkg.sv -----
package ptm_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned DEF_MAX_FRAMES = 1024;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FCOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINDEX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic [2:0] MODE_DISSOLVE = 3'd0;
  localparam logic [2:0] MODE_LR       = 3'd1;
  localparam logic [2:0] MODE_RL       = 3'd2;
  localparam logic [2:0] MODE_BT       = 3'd3;
  localparam logic [2:0] MODE_TB       = 3'd4;
  localparam logic [2:0] MODE_CIRCLE   = 3'd5;

  // How a pixel is finally formed.
  localparam logic [1:0] CLS_A     = 2'd0;
  localparam logic [1:0] CLS_B     = 2'd1;
  localparam logic [1:0] CLS_MIX   = 2'd2;
  localparam logic [1:0] CLS_SHADE = 2'd3;

  // Wipe decision for the whole frame.
  localparam logic [1:0] WS_A   = 2'd0;
  localparam logic [1:0] WS_B   = 2'd1;
  localparam logic [1:0] WS_CMP = 2'd2;

  localparam int unsigned OP_W   = 42;
  localparam int unsigned ROOT_W = 21;
  localparam int unsigned SREM_W = 24;
  localparam int unsigned RIM_W  = 21;
  localparam int unsigned CUR_W  = 23;
  localparam int unsigned Q_W    = 16;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [15:0] SHADE_Q16 = 16'd52429;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  first_red;
    logic [7:0]  first_green;
    logic [7:0]  first_blue;
    logic [7:0]  second_red;
    logic [7:0]  second_green;
    logic [7:0]  second_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] mixed_red;
    logic [7:0] mixed_green;
    logic [7:0] mixed_blue;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]              mode;
    logic [16:0]             t;
    logic [1:0]              wsel;
    logic [12:0]             thr;
    logic [20:0]             hw;
    logic [20:0]             hh;
    logic [CUR_W-1:0]        cur;
    logic [RIM_W-1:0]        rim;
    logic signed [CUR_W:0]   shadow;
  } frm_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] ar;
    logic [7:0] ag;
    logic [7:0] ab;
    logic [7:0] br;
    logic [7:0] bg;
    logic [7:0] bb;
  } side_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

  // One result bit of a restoring square root.
  function automatic sqrt_res_t sqrt_step(logic [SREM_W-1:0] rem, logic [ROOT_W-1:0] root,
                                          logic [1:0] bits);
    sqrt_res_t res;
    logic [SREM_W+1:0] cand;
    logic [SREM_W+1:0] trial;
    cand  = {rem, bits};
    trial = (SREM_W+2)'({root, 2'b01});
    if (cand >= trial) begin
      res.rem  = SREM_W'(cand - trial);
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = SREM_W'(cand);
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [7:0] lerp8(logic [7:0] p, logic [7:0] q, logic [16:0] w);
    logic [16:0] wa;
    logic [24:0] pa;
    logic [24:0] pb;
    logic [24:0] s;
    wa = ONE_Q16 - w;
    pa = 25'(wa) * 25'(p);
    pb = 25'(w) * 25'(q);
    s  = pa + pb;
    return s[23:16];
  endfunction

endpackage

// ----- rtl/ptm_root_pipe.sv -----
module ptm_root_pipe
  import ptm_pkg::*;
#(
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [OP_W-1:0]   in_op,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [ROOT_W];
  logic [SREM_W-1:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [OP_W-1:0]   op_r   [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic              v_in;
    logic [SREM_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [OP_W-1:0]   op_in;
    logic [SIDE_W-1:0] side_in;
    sqrt_res_t         res;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = in_op;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign op_in   = op_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign res = sqrt_step(rem_in, root_in, op_in[OP_W-1 -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= res.rem;
        root_r[k] <= res.root;
        op_r[k]   <= {op_in[OP_W-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ----- rtl/ptm_div_pipe.sv -----
module ptm_div_pipe
  import ptm_pkg::*;
#(
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [RIM_W-1:0]  den,
  input  logic              in_vld,
  input  logic [RIM_W-1:0]  in_rem,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [Q_W];
  logic [RIM_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic              v_in;
    logic [RIM_W-1:0]  rem_in;
    logic [Q_W-1:0]    q_in;
    logic [SIDE_W-1:0] side_in;
    logic [RIM_W:0]    r2;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = in_rem;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign r2 = {rem_in, 1'b0};
    assign ge = r2 >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? RIM_W'(r2 - {1'b0, den}) : r2[RIM_W-1:0];
        q_r[k]    <= {q_in[Q_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_quot = q_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

// ----- rtl/ptm_frame_calc.sv -----
module ptm_frame_calc
  import ptm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  busy,
  output frm_t                  frm
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_PREP = 8'b00000010,
    ST_SQ   = 8'b00000100,
    ST_SUM  = 8'b00001000,
    ST_ROOT = 8'b00010000,
    ST_MULR = 8'b00100000,
    ST_DIV  = 8'b01000000,
    ST_FIN  = 8'b10000000
  } st_t;

  st_t state_r, state_nxt;

  logic [2:0]  mode_r;
  logic [10:0] fcnt_r;
  logic [9:0]  fidx_r;
  logic [12:0] wid_r;
  logic [12:0] hgt_r;
  logic        restart_r;

  logic [10:0] fc;
  logic [12:0] w;
  logic [12:0] h;
  logic [10:0] last;
  logic [9:0]  f;

  logic [9:0]  f_r;
  logic [10:0] dden_r;
  logic [10:0] d_r;
  logic [20:0] hw_r;
  logic [20:0] hh_r;
  logic [10:0] fac_r;
  logic [12:0] dim_r;
  logic [1:0]  wsel_r;
  logic [41:0] hw2_r;
  logic [41:0] hh2_r;
  logic [23:0] wp_r;
  logic [OP_W-1:0]   sq_op_r;
  logic [SREM_W-1:0] sq_rem_r;
  logic [ROOT_W-1:0] sq_root_r;
  sqrt_res_t         sq_res;
  logic [31:0] fr_r;
  logic [4:0]  cnt_r;
  logic [1:0]  job_r;
  logic [31:0] dv_num_r;
  logic [10:0] dv_den_r;
  logic [10:0] dv_rem_r;
  logic [31:0] dv_q_r;
  logic [11:0] dv_r2;
  logic        dv_ge;
  logic [31:0] dv_q_nxt;
  logic [31:0] ld_num;
  logic [10:0] ld_den;

  logic [16:0]      t_r;
  logic [12:0]      thr_r;
  logic [CUR_W-1:0] cur_r;
  logic [RIM_W-1:0] rim_r;
  logic signed [CUR_W:0] shadow_r;

  // A write during a recompute keeps the request pending, so the run repeats
  // with the newest registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DISSOLVE;
      fcnt_r    <= 11'd10;
      fidx_r    <= 10'd0;
      wid_r     <= 13'd400;
      hgt_r     <= 13'd400;
      restart_r <= 1'b1;
    end else begin
      restart_r <= cfg_we || (restart_r && state_r != ST_IDLE);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode_r <= cfg_wdata[2:0];
          REG_FCOUNT: fcnt_r <= cfg_wdata[10:0];
          REG_FINDEX: fidx_r <= cfg_wdata[9:0];
          REG_WIDTH:  wid_r  <= cfg_wdata;
          REG_HEIGHT: hgt_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign fc   = (32'(fcnt_r) > 32'(MAX_FRAMES)) ? 11'(MAX_FRAMES) : fcnt_r;
  assign w    = (32'(wid_r) > 32'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : wid_r;
  assign h    = (32'(hgt_r) > 32'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : hgt_r;
  assign last = (fc == 11'd0) ? 11'd0 : fc - 11'd1;
  assign f    = ({1'b0, fidx_r} > last) ? last[9:0] : fidx_r;

  assign sq_res = sqrt_step(sq_rem_r, sq_root_r, sq_op_r[OP_W-1 -: 2]);

  assign dv_r2    = {dv_rem_r, dv_num_r[31]};
  assign dv_ge    = dv_r2 >= {1'b0, dv_den_r};
  assign dv_q_nxt = {dv_q_r[30:0], dv_ge};

  // Operands of the division that follows the current one.
  always_comb begin
    unique case (job_r)
      2'd0: begin ld_num = 32'(wp_r); ld_den = dden_r; end
      2'd1: begin ld_num = fr_r;      ld_den = d_r;    end
      2'd2: begin ld_num = 32'(sq_root_r); ld_den = d_r; end
      2'd3: begin ld_num = fr_r;      ld_den = d_r;    end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (restart_r) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ROOT;
      ST_ROOT: if (cnt_r == 5'(ROOT_W - 1)) state_nxt = ST_MULR;
      ST_MULR: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd31 && job_r == 2'd3) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_PREP: begin
        f_r    <= f;
        dden_r <= (last == 11'd0) ? 11'd1 : last;
        d_r    <= (fc >= 11'd3) ? fc - 11'd2 : 11'd1;
        hw_r   <= 21'({w, 7'b0}) + 21'd256;
        hh_r   <= 21'({h, 7'b0}) + 21'd256;
        fac_r  <= (mode_r == MODE_LR || mode_r == MODE_TB) ? {1'b0, f} : last - {1'b0, f};
        dim_r  <= (mode_r == MODE_LR || mode_r == MODE_RL) ? w : h;
        if (f == 10'd0) begin
          wsel_r <= WS_A;
        end else if ({1'b0, f} == last) begin
          wsel_r <= WS_B;
        end else begin
          wsel_r <= WS_CMP;
        end
      end
      ST_SQ: begin
        hw2_r <= 42'(hw_r) * 42'(hw_r);
        hh2_r <= 42'(hh_r) * 42'(hh_r);
        wp_r  <= 24'(fac_r) * 24'(dim_r);
      end
      ST_SUM: begin
        sq_op_r   <= hw2_r + hh2_r;
        sq_rem_r  <= '0;
        sq_root_r <= '0;
        cnt_r     <= '0;
      end
      ST_ROOT: begin
        sq_op_r   <= {sq_op_r[OP_W-3:0], 2'b00};
        sq_rem_r  <= sq_res.rem;
        sq_root_r <= sq_res.root;
        cnt_r     <= cnt_r + 5'd1;
      end
      ST_MULR: begin
        fr_r     <= 32'(f_r) * 32'(sq_root_r);
        dv_num_r <= {6'b0, f_r, 16'b0};
        dv_den_r <= dden_r;
        dv_rem_r <= '0;
        dv_q_r   <= '0;
        cnt_r    <= '0;
        job_r    <= 2'd0;
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          unique case (job_r)
            2'd0: t_r   <= dv_q_nxt[16:0];
            2'd1: thr_r <= dv_q_nxt[12:0];
            2'd2: cur_r <= dv_q_nxt[CUR_W-1:0];
            2'd3: rim_r <= dv_q_nxt[RIM_W-1:0];
          endcase
          job_r    <= job_r + 2'd1;
          dv_num_r <= ld_num;
          dv_den_r <= ld_den;
          dv_rem_r <= '0;
          dv_q_r   <= '0;
        end else begin
          dv_num_r <= {dv_num_r[30:0], 1'b0};
          dv_rem_r <= dv_ge ? 11'(dv_r2 - {1'b0, dv_den_r}) : dv_r2[10:0];
          dv_q_r   <= dv_q_nxt;
        end
      end
      ST_FIN: begin
        shadow_r <= $signed({1'b0, cur_r}) - $signed({3'b0, rim_r});
      end
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE) || restart_r;

  assign frm.mode   = mode_r;
  assign frm.t      = t_r;
  assign frm.wsel   = wsel_r;
  assign frm.thr    = thr_r;
  assign frm.hw     = hw_r;
  assign frm.hh     = hh_r;
  assign frm.cur    = cur_r;
  assign frm.rim    = rim_r;
  assign frm.shadow = shadow_r;

endmodule

// ----- rtl/pixel_transition_mixer_top.sv -----
// Channel  | Ports                                  | Beat
// ---------+----------------------------------------+-----------------------------
// input    | in_valid, in_stall, in_data            | pixel position, pixels A, B
// result   | out_valid, out_stall, out_data         | mixed pixel
// config   | cfg_we, cfg_index, cfg_wdata           | one register write
//
// One pixel enters per cycle while in_stall is low.
// Every config write, and reset, starts a recompute of the frame constants
// (square root and four 32-step divisions in one shared sequential unit);
// a single write holds in_stall high until the recompute is done, the write cycle included.
// A high out_stall with a result waiting freezes the whole pipeline.
// Reset is synchronous and loads the default registers.
module pixel_transition_mixer_top
  import ptm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned SIDE_W = $bits(side_t);

  frm_t  frm;
  logic  busy;
  logic  adv;

  logic      a_vld_r;
  in_beat_t  a_dat_r;

  logic        b_vld_r;
  logic [20:0] b_adx_r;
  logic [20:0] b_ady_r;
  side_t       b_side_r;
  side_t       b_side_nxt;
  logic signed [21:0] dx;
  logic signed [21:0] dy;
  logic        hit;

  logic        c_vld_r;
  logic [41:0] c_sqx_r;
  logic [41:0] c_sqy_r;
  side_t       c_side_r;

  logic            d_vld_r;
  logic [OP_W-1:0] d_sum_r;
  side_t           d_side_r;

  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  logic [SIDE_W-1:0] rt_side;
  side_t             rt_s;

  logic              e_vld_r;
  logic [RIM_W-1:0]  e_diff_r;
  side_t             e_side_r;
  side_t             e_side_nxt;
  logic signed [CUR_W:0] r_s;
  logic signed [CUR_W:0] diff;

  logic              dv_vld;
  logic [Q_W-1:0]    dv_quot;
  logic [SIDE_W-1:0] dv_side;

  logic        f_vld_r;
  logic [15:0] f_k_r;
  side_t       f_side_r;
  logic [31:0] kprod;

  logic      out_valid_r;
  out_beat_t out_data_r;
  out_beat_t out_nxt;

  ptm_frame_calc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_frame_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .frm       (frm)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || busy || cfg_we;

  // Stage A: input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dat_r <= in_data;
    end
  end

  // Stage B: offsets from the circle center and the wipe decision.
  assign dx = $signed({2'b0, a_dat_r.pixel_x, 8'b0}) - $signed({1'b0, frm.hw});
  assign dy = $signed({2'b0, a_dat_r.pixel_y, 8'b0}) - $signed({1'b0, frm.hh});

  always_comb begin
    unique case (frm.mode)
      MODE_LR: hit = {1'b0, a_dat_r.pixel_x} < frm.thr;
      MODE_RL: hit = {1'b0, a_dat_r.pixel_x} > frm.thr;
      MODE_BT: hit = {1'b0, a_dat_r.pixel_y} > frm.thr;
      MODE_TB: hit = {1'b0, a_dat_r.pixel_y} < frm.thr;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    b_side_nxt.ar = a_dat_r.first_red;
    b_side_nxt.ag = a_dat_r.first_green;
    b_side_nxt.ab = a_dat_r.first_blue;
    b_side_nxt.br = a_dat_r.second_red;
    b_side_nxt.bg = a_dat_r.second_green;
    b_side_nxt.bb = a_dat_r.second_blue;
    unique case (frm.mode)
      MODE_DISSOLVE: b_side_nxt.cls = CLS_MIX;
      MODE_LR, MODE_RL, MODE_BT, MODE_TB: begin
        b_side_nxt.cls = (frm.wsel == WS_B || (frm.wsel == WS_CMP && hit)) ? CLS_B : CLS_A;
      end
      default: b_side_nxt.cls = CLS_A;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_adx_r  <= dx[21] ? 21'(-dx) : dx[20:0];
      b_ady_r  <= dy[21] ? 21'(-dy) : dy[20:0];
      b_side_r <= b_side_nxt;
    end
  end

  // Stage C: squares. Stage D: their sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sqx_r  <= 42'(b_adx_r) * 42'(b_adx_r);
      c_sqy_r  <= 42'(b_ady_r) * 42'(b_ady_r);
      c_side_r <= b_side_r;
      d_sum_r  <= c_sqx_r + c_sqy_r;
      d_side_r <= c_side_r;
    end
  end

  ptm_root_pipe #(
    .SIDE_W (SIDE_W)
  ) u_root_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d_vld_r),
    .in_op    (d_sum_r),
    .in_side  (d_side_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  // Stage E: place the radius against the shadow edge and the rim.
  assign rt_s = side_t'(rt_side);
  assign r_s  = $signed({3'b0, rt_root});
  assign diff = r_s - frm.shadow;

  always_comb begin
    e_side_nxt = rt_s;
    if (frm.mode == MODE_CIRCLE) begin
      if (r_s < frm.shadow) begin
        e_side_nxt.cls = CLS_B;
      end else if ({2'b0, rt_root} < frm.cur && frm.rim != '0) begin
        e_side_nxt.cls = CLS_SHADE;
      end else begin
        e_side_nxt.cls = CLS_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_diff_r <= diff[RIM_W-1:0];
      e_side_r <= e_side_nxt;
    end
  end

  ptm_div_pipe #(
    .SIDE_W (SIDE_W)
  ) u_div_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .den      (frm.rim),
    .in_vld   (e_vld_r),
    .in_rem   (e_diff_r),
    .in_side  (e_side_r),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_side (dv_side)
  );

  // Stage F: shade weight, 0.8 times the rim fraction.
  assign kprod = 32'(dv_quot) * 32'(SHADE_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_k_r    <= kprod[31:16];
      f_side_r <= side_t'(dv_side);
    end
  end

  // Output register.
  always_comb begin
    unique case (f_side_r.cls)
      CLS_A: begin
        out_nxt.mixed_red   = f_side_r.ar;
        out_nxt.mixed_green = f_side_r.ag;
        out_nxt.mixed_blue  = f_side_r.ab;
      end
      CLS_B: begin
        out_nxt.mixed_red   = f_side_r.br;
        out_nxt.mixed_green = f_side_r.bg;
        out_nxt.mixed_blue  = f_side_r.bb;
      end
      CLS_MIX: begin
        out_nxt.mixed_red   = lerp8(f_side_r.ar, f_side_r.br, frm.t);
        out_nxt.mixed_green = lerp8(f_side_r.ag, f_side_r.bg, frm.t);
        out_nxt.mixed_blue  = lerp8(f_side_r.ab, f_side_r.bb, frm.t);
      end
      CLS_SHADE: begin
        out_nxt.mixed_red   = lerp8(f_side_r.br, 8'd0, {1'b0, f_k_r});
        out_nxt.mixed_green = lerp8(f_side_r.bg, 8'd0, {1'b0, f_k_r});
        out_nxt.mixed_blue  = lerp8(f_side_r.bb, 8'd0, {1'b0, f_k_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- dv/pixel_transition_mixer_checker.sv -----
module pixel_transition_mixer_checker
  import ptm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  logic [2:0]  mix_mode;
  logic [10:0] frames;
  logic [9:0]  frame_now;
  logic [12:0] width;
  logic [12:0] height;

  out_beat_t mixed_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] blend(longint unsigned p, longint unsigned q,
                                       longint unsigned t);
    longint unsigned s;
    s = ((65536 - t) * p + t * q) >> 16;
    return s[7:0];
  endfunction

  function automatic out_beat_t mix_pixel(in_beat_t p);
    longint fc, w, h, last, f, x, y, t, c;
    longint hw, hh, big, d, cur, rim, shadow, dx, dy, r;
    longint unsigned s, k;
    logic take_b;
    out_beat_t o;
    fc = (frames > 1024) ? 1024 : frames;
    w = (width > 4096) ? 4096 : width;
    h = (height > 4096) ? 4096 : height;
    last = (fc > 0) ? fc - 1 : 0;
    f = (frame_now > last) ? last : frame_now;
    x = p.pixel_x;
    y = p.pixel_y;
    o = '{p.first_red, p.first_green, p.first_blue};
    take_b = 1'b0;
    case (mix_mode)
      MODE_DISSOLVE: begin
        t = (f << 16) / ((last > 0) ? last : 1);
        if (t > 65536) t = 65536;
        o.mixed_red   = blend(p.first_red, p.second_red, t);
        o.mixed_green = blend(p.first_green, p.second_green, t);
        o.mixed_blue  = blend(p.first_blue, p.second_blue, t);
      end
      MODE_LR, MODE_RL, MODE_BT, MODE_TB: begin
        if (f == 0) take_b = 1'b0;
        else if (f == last) take_b = 1'b1;
        else begin
          case (mix_mode)
            MODE_LR: take_b = x < (f * w) / last;
            MODE_RL: take_b = x > ((last - f) * w) / last;
            MODE_BT: take_b = y > ((last - f) * h) / last;
            default: take_b = y < (f * h) / last;
          endcase
        end
      end
      MODE_CIRCLE: begin
        hw = (w << 7) + 256;
        hh = (h << 7) + 256;
        big = int_sqrt(hw * hw + hh * hh);
        d = (fc >= 2) ? fc - 2 : 1;
        if (d == 0) d = 1;
        cur = (f * big) / d;
        rim = big / d;
        shadow = cur - rim;
        dx = (x << 8) - hw;
        dy = (y << 8) - hh;
        r = int_sqrt(dx * dx + dy * dy);
        if (r < shadow) begin
          take_b = 1'b1;
        end else if (r < cur && rim > 0) begin
          s = ((r - shadow) << 16) / rim;
          k = (s * 52429) >> 16;
          if (k > 65536) k = 65536;
          o.mixed_red   = blend(p.second_red, 0, k);
          o.mixed_green = blend(p.second_green, 0, k);
          o.mixed_blue  = blend(p.second_blue, 0, k);
        end
      end
      default: ;
    endcase
    if (take_b) o = '{p.second_red, p.second_green, p.second_blue};
    return o;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      mix_mode  = MODE_DISSOLVE;
      frames    = 11'd10;
      frame_now = 10'd0;
      width     = 13'd400;
      height    = 13'd400;
    end else begin
      if (out_valid && !out_stall) begin
        if (mixed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", out_data);
        end else begin
          want = mixed_q.pop_front();
          if (out_data !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: red %h/%h green %h/%h blue %h/%h (expected/actual)",
                       want.mixed_red, out_data.mixed_red, want.mixed_green,
                       out_data.mixed_green, want.mixed_blue, out_data.mixed_blue);
          end
        end
      end
      // The prediction uses the registers as they stand before this edge.
      if (in_valid && !in_stall) mixed_q.push_back(mix_pixel(in_data));
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mix_mode  = cfg_wdata[2:0];
          REG_FCOUNT: frames    = cfg_wdata[10:0];
          REG_FINDEX: frame_now = cfg_wdata[9:0];
          REG_WIDTH:  width     = cfg_wdata;
          REG_HEIGHT: height    = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = mixed_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

// ----- dv/pixel_transition_mixer_top_test.sv -----
module pixel_transition_mixer_top_test;
  import ptm_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int errors;
  int pending;

  int cur_w;
  int cur_h;
  int stall_pct;
  int stall_cnt;
  in_beat_t pixel_list[$];

  pixel_transition_mixer_top dut (.*);

  pixel_transition_mixer_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver switches between no stall, light and heavy stalling.
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_cnt = $urandom_range(16, 120);
      case ($urandom_range(0, 3))
        0, 1: stall_pct = 0;
        2: stall_pct = 30;
        default: stall_pct = 80;
      endcase
    end
    stall_cnt--;
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  task automatic wait_idle();
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    repeat (2) @(posedge clk);
    wait_idle();
  endtask

  // Waits for every result, then for the pipeline latency, and rewrites all registers.
  task automatic setup(input logic [2:0] m, input int fc, input int fi, input int w,
                       input int h);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(REG_MODE, int'(m));
    write_reg(REG_FCOUNT, fc);
    write_reg(REG_FINDEX, fi);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cur_w = (w > 4096) ? 4096 : w;
    cur_h = (h > 4096) ? 4096 : h;
  endtask

  task automatic stage(input int x, input int y, input int a, input int b);
    in_beat_t p;
    p.pixel_x = x[11:0];
    p.pixel_y = y[11:0];
    p.first_red = a[7:0];
    p.first_green = a[15:8];
    p.first_blue = a[23:16];
    p.second_red = b[7:0];
    p.second_green = b[15:8];
    p.second_blue = b[23:16];
    pixel_list.push_back(p);
  endtask

  task automatic stage_random(input int n);
    int x, y;
    repeat (n) begin
      x = (cur_w > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, cur_w - 1)
                                                   : $urandom_range(0, 4095);
      y = (cur_h > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, cur_h - 1)
                                                   : $urandom_range(0, 4095);
      stage(x, y, $urandom_range(0, 24'hffffff), $urandom_range(0, 24'hffffff));
    end
  endtask

  // Sends the staged pixels in bursts with random gaps between them.
  task automatic send_pixels();
    int burst;
    burst = $urandom_range(1, 24);
    while (pixel_list.size() != 0) begin
      @(negedge clk);
      in_valid = 1'b1;
      in_data = pixel_list.pop_front();
      do @(posedge clk); while (in_stall);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 4096;
      3: return 8191;
      4: return $urandom_range(1, 4096);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  initial begin
    int fc, fi;
    logic [2:0] m;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    stall_cnt = 0;
    stall_pct = 0;
    cfg_we = 0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    cur_w = 400;
    cur_h = 400;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // Reset defaults: dissolve on the first frame.
    stage(0, 0, 24'hffffff, 24'h000000);
    stage(399, 399, 24'h000000, 24'hffffff);
    send_pixels();

    setup(MODE_DISSOLVE, 3, 1, 4, 4);
    stage(4095, 0, 24'hff00ff, 24'h00ff00);
    stage(0, 4095, 24'h123456, 24'hfedcba);
    send_pixels();
    // Frame index past the last frame acts as the last frame.
    setup(MODE_DISSOLVE, 3, 1023, 4, 4);
    stage(1, 1, 24'hffffff, 24'h0000ff);
    send_pixels();
    // A transition of zero frames stays on the first frame.
    setup(MODE_LR, 0, 5, 8, 8);
    stage(0, 0, 24'h0000ff, 24'hff0000);
    send_pixels();
    setup(MODE_LR, 5, 2, 8, 8);
    stage(0, 0, 24'h010203, 24'hfffefd);
    stage(7, 0, 24'h010203, 24'hfffefd);
    send_pixels();
    setup(MODE_RL, 5, 2, 8, 8);
    stage(0, 3, 24'h0000aa, 24'h00bb00);
    stage(7, 3, 24'h0000aa, 24'h00bb00);
    send_pixels();
    setup(MODE_BT, 5, 2, 8, 8);
    stage(3, 0, 24'h0000aa, 24'h00bb00);
    stage(3, 7, 24'h0000aa, 24'h00bb00);
    send_pixels();
    setup(MODE_TB, 5, 2, 8, 8);
    stage(3, 0, 24'h0000aa, 24'h00bb00);
    stage(3, 7, 24'h0000aa, 24'h00bb00);
    send_pixels();
    // Two frames leave a zero divisor in the circle, which becomes one.
    setup(MODE_CIRCLE, 2, 1, 16, 16);
    stage(8, 8, 24'h102030, 24'hffffff);
    stage(0, 0, 24'h102030, 24'hffffff);
    send_pixels();
    setup(MODE_CIRCLE, 12, 5, 16, 16);
    stage(8, 8, 24'h102030, 24'hffffff);
    stage(4, 9, 24'h102030, 24'hffffff);
    stage(2, 12, 24'h102030, 24'hffffff);
    stage(0, 0, 24'h102030, 24'hffffff);
    send_pixels();
    // Spare modes pass A; oversized registers are clamped and zero size is kept.
    setup(MODE_SPARE_HI, 2047, 1023, 8191, 0);
    stage(4095, 4095, 24'habcdef, 24'h000000);
    send_pixels();
    setup(MODE_CIRCLE, 2047, 1023, 8191, 0);
    stage(4095, 4095, 24'habcdef, 24'h5a5a5a);
    send_pixels();

    for (int ph = 0; ph < 40; ph++) begin
      case ($urandom_range(0, 9))
        0: m = MODE_SPARE_LO;
        1: m = MODE_SPARE_HI;
        2, 3: m = MODE_CIRCLE;
        default: m = 3'($urandom_range(MODE_DISSOLVE, MODE_TB));
      endcase
      case ($urandom_range(0, 7))
        0: fc = $urandom_range(0, 1);
        1: fc = 2;
        2: fc = 1024;
        3: fc = 2047;
        default: fc = $urandom_range(3, 40);
      endcase
      case ($urandom_range(0, 5))
        0: fi = 0;
        1: fi = (fc > 0) ? fc - 1 : 0;
        2: fi = 1023;
        default: fi = $urandom_range(0, (fc > 1024) ? 1023 : ((fc > 0) ? fc - 1 : 0));
      endcase
      setup(m, fc, fi, pick_size(), pick_size());
      stage_random(30);
      send_pixels();
    end

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
